### hw/rtl/lrle_pkg.sv
// Shared types, character codes and reset constants for the Life RLE pattern decoder.
package lrle_pkg;

  // Default coordinate width and fixed field widths.
  parameter int COORD_BITS_DEF = 16;
  parameter int FIELD_BITS     = 16;
  parameter int COUNT_BITS     = 16;
  parameter int RULE_BITS      = 4;

  // Pattern text characters.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_BANG    = 8'd33;  // '!'
  localparam logic [7:0] CH_HASH    = 8'd35;  // '#'
  localparam logic [7:0] CH_DOLLAR  = 8'd36;  // '$'
  localparam logic [7:0] CH_ZERO    = 8'd48;  // '0'
  localparam logic [7:0] CH_NINE    = 8'd57;  // '9'
  localparam logic [7:0] CH_UPPER_B = 8'd66;  // 'B'
  localparam logic [7:0] CH_LOWER_B = 8'd98;  // 'b'
  localparam logic [7:0] CH_LOWER_O = 8'd111; // 'o'
  localparam logic [7:0] CH_LOWER_X = 8'd120; // 'x'

  // Reset values.
  localparam logic [FIELD_BITS-1:0] GRID_RESET  = 16'd256;
  localparam logic [11:0]           RULES_RESET = 12'h323; // born 3, survive 2 to 3
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 16'hFFFF;

  // Configuration register indexes.
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // Line classification.
  typedef enum logic [4:0] {
    MODE_START    = 5'b00001,
    MODE_SKIP     = 5'b00010,
    MODE_HEADER   = 5'b00100,
    MODE_HDR_DONE = 5'b01000,
    MODE_BODY     = 5'b10000
  } line_mode_t;

  // Position inside the header line.
  typedef enum logic [7:0] {
    HP_WIDTH         = 8'h01,
    HP_WIDTH_DIGITS  = 8'h02,
    HP_HEIGHT        = 8'h04,
    HP_HEIGHT_DIGITS = 8'h08,
    HP_RULE_LETTER   = 8'h10,
    HP_BORN          = 8'h20,
    HP_SURV_MIN      = 8'h40,
    HP_SURV_MAX      = 8'h80
  } hdr_phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_RUN    = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_END    = 2'd2
  } result_kind_t;

  // One result item with its valid flag.
  typedef struct packed {
    logic                  valid;
    result_kind_t          kind;
    logic [FIELD_BITS-1:0] row;
    logic [FIELD_BITS-1:0] column;
    logic [FIELD_BITS-1:0] run_length;
    logic [FIELD_BITS-1:0] used_width;
    logic [FIELD_BITS-1:0] used_height;
    logic [RULE_BITS-1:0]  born_count;
    logic [RULE_BITS-1:0]  survive_min;
    logic [RULE_BITS-1:0]  survive_max;
  } result_t;

endpackage

### hw/rtl/lrle_core.sv
// Parser state and per-byte next-state logic of the Life RLE pattern decoder.
module lrle_core
  import lrle_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            char_byte,
  input  logic [FIELD_BITS-1:0] grid_width,
  input  logic [FIELD_BITS-1:0] grid_height,
  output result_t               result
);

  localparam int PW = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int AW = COORD_BITS + 4;
  localparam int CW = COUNT_BITS + 4;
  localparam logic [AW-1:0] COORD_MAX_A = AW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [PW:0]   COORD_MAX_P = (PW+1)'((64'd1 << COORD_BITS) - 64'd1);

  // State registers.
  line_mode_t            line_mode, line_mode_next;
  hdr_phase_t            phase, phase_next;
  logic [COUNT_BITS-1:0] acc, acc_next;
  logic                  seen, seen_next;
  logic [COORD_BITS-1:0] pat_w, pat_w_next;
  logic [COORD_BITS-1:0] pat_h, pat_h_next;
  logic [11:0]           rules, rules_next;
  logic [PW-1:0]         start_col, start_col_next;
  logic [PW-1:0]         cur_row, cur_row_next;
  logic [PW-1:0]         cur_col, cur_col_next;
  logic                  finished, finished_next;

  // Byte classification.
  logic                 is_digit, is_b_letter;
  logic [3:0]           digit;
  logic                 do_body;

  // Header number accumulator.
  logic [COORD_BITS-1:0] hbase;
  logic [AW-1:0]         hbase_ext, hsum;
  logic [COORD_BITS-1:0] hacc;

  // Run count accumulator.
  logic [CW-1:0]         csum;
  logic [COUNT_BITS-1:0] cacc, count;

  // Placement and cursor arithmetic.
  logic [PW-1:0] gw_e, gh_e, pw_e, ph_e, uw, uh, start_calc, row_calc;
  logic [PW:0]   col_sum, row_sum;
  logic [PW-1:0] col_sat, row_sat;

  assign is_digit    = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_b_letter = (char_byte == CH_UPPER_B) || (char_byte == CH_LOWER_B);
  // '0' is a multiple of 16, so byte minus 48 mod 16 is the low nibble.
  assign digit       = char_byte[3:0];

  // Header numbers restart at the first digit and saturate at the coordinate maximum.
  always_comb begin
    hbase = '0;
    if (phase == HP_WIDTH_DIGITS) begin
      hbase = pat_w;
    end else if (phase == HP_HEIGHT_DIGITS) begin
      hbase = pat_h;
    end
  end
  assign hbase_ext = AW'(hbase);
  assign hsum      = (hbase_ext << 3) + (hbase_ext << 1) + AW'(digit);
  assign hacc      = (hsum > COORD_MAX_A) ? COORD_BITS'(COORD_MAX_A) : hsum[COORD_BITS-1:0];

  // Run count: decimal with saturation, 1 when no digit came.
  assign csum  = (CW'(acc) << 3) + (CW'(acc) << 1) + CW'(digit);
  assign cacc  = (csum[CW-1:COUNT_BITS] != '0) ? COUNT_MAX : csum[COUNT_BITS-1:0];
  assign count = seen ? acc : COUNT_BITS'(1);

  // Placement of the pattern centered in the larger of grid and pattern.
  assign gw_e       = PW'(grid_width);
  assign gh_e       = PW'(grid_height);
  assign pw_e       = PW'(pat_w);
  assign ph_e       = PW'(pat_h);
  assign uw         = (gw_e > pw_e) ? gw_e : pw_e;
  assign uh         = (gh_e > ph_e) ? gh_e : ph_e;
  assign start_calc = (uw >> 1) - (pw_e >> 1);
  assign row_calc   = (uh - ph_e) >> 1;

  // Saturating cursor moves.
  assign col_sum = {1'b0, cur_col} + (PW+1)'(count);
  assign row_sum = {1'b0, cur_row} + (PW+1)'(count);
  assign col_sat = (col_sum > COORD_MAX_P) ? PW'(COORD_MAX_P) : col_sum[PW-1:0];
  assign row_sat = (row_sum > COORD_MAX_P) ? PW'(COORD_MAX_P) : row_sum[PW-1:0];

  // Next state and result for the byte in the input register.
  always_comb begin
    line_mode_next = line_mode;
    phase_next     = phase;
    acc_next       = acc;
    seen_next      = seen;
    pat_w_next     = pat_w;
    pat_h_next     = pat_h;
    rules_next     = rules;
    start_col_next = start_col;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    finished_next  = finished;
    do_body        = 1'b0;
    result         = '0;

    if (step) begin
      if (char_byte == CH_NEWLINE) begin
        line_mode_next = MODE_START;
        // End of a header line: place the pattern and report it.
        if (line_mode == MODE_HEADER || line_mode == MODE_HDR_DONE) begin
          phase_next         = HP_WIDTH;
          start_col_next     = start_calc;
          cur_row_next       = row_calc;
          cur_col_next       = start_calc;
          finished_next      = 1'b0;
          acc_next           = '0;
          seen_next          = 1'b0;
          result.valid       = 1'b1;
          result.kind        = KIND_HEADER;
          result.row         = row_calc[FIELD_BITS-1:0];
          result.column      = start_calc[FIELD_BITS-1:0];
          result.used_width  = uw[FIELD_BITS-1:0];
          result.used_height = uh[FIELD_BITS-1:0];
          result.born_count  = rules[3:0];
          result.survive_min = rules[7:4];
          result.survive_max = rules[11:8];
        end
      end else begin
        unique case (line_mode)
          MODE_START: begin
            if (char_byte == CH_HASH) begin
              line_mode_next = MODE_SKIP;
              phase_next     = HP_WIDTH;
            end else if (char_byte == CH_LOWER_X) begin
              line_mode_next = MODE_HEADER;
              phase_next     = HP_WIDTH;
              pat_w_next     = '0;
              pat_h_next     = '0;
              rules_next     = RULES_RESET;
            end else begin
              line_mode_next = MODE_BODY;
              do_body        = 1'b1;
            end
          end
          MODE_HEADER: begin
            unique case (phase)
              HP_WIDTH: begin
                if (is_digit) begin
                  pat_w_next = hacc;
                  phase_next = HP_WIDTH_DIGITS;
                end
              end
              HP_WIDTH_DIGITS: begin
                if (is_digit) begin
                  pat_w_next = hacc;
                end else begin
                  phase_next = HP_HEIGHT;
                end
              end
              HP_HEIGHT: begin
                if (is_digit) begin
                  pat_h_next = hacc;
                  phase_next = HP_HEIGHT_DIGITS;
                end
              end
              HP_HEIGHT_DIGITS: begin
                if (is_digit) begin
                  pat_h_next = hacc;
                end else begin
                  phase_next = is_b_letter ? HP_BORN : HP_RULE_LETTER;
                end
              end
              HP_RULE_LETTER: begin
                if (is_b_letter) begin
                  phase_next = HP_BORN;
                end
              end
              HP_BORN: begin
                rules_next[3:0] = digit;
                phase_next      = HP_SURV_MIN;
              end
              HP_SURV_MIN: begin
                if (is_digit) begin
                  rules_next[7:4] = digit;
                  phase_next      = HP_SURV_MAX;
                end
              end
              HP_SURV_MAX: begin
                // The rest of the header line is ignored.
                rules_next[11:8] = digit;
                line_mode_next   = MODE_HDR_DONE;
              end
              default: begin
                phase_next = phase;
              end
            endcase
          end
          MODE_BODY: begin
            do_body = 1'b1;
          end
          default: begin
            line_mode_next = line_mode;
          end
        endcase
      end
    end

    // Body tags and run counts; nothing happens after the pattern end.
    if (do_body && !finished) begin
      if (char_byte == CH_BANG) begin
        finished_next = 1'b1;
        acc_next      = '0;
        seen_next     = 1'b0;
        result.valid  = 1'b1;
        result.kind   = KIND_END;
        result.row    = cur_row[FIELD_BITS-1:0];
        result.column = cur_col[FIELD_BITS-1:0];
      end else if (is_digit) begin
        acc_next  = cacc;
        seen_next = 1'b1;
      end else begin
        acc_next  = '0;
        seen_next = 1'b0;
        unique case (char_byte)
          CH_LOWER_B: begin
            cur_col_next = col_sat;
          end
          CH_LOWER_O: begin
            cur_col_next      = col_sat;
            result.valid      = 1'b1;
            result.kind       = KIND_RUN;
            result.row        = cur_row[FIELD_BITS-1:0];
            result.column     = cur_col[FIELD_BITS-1:0];
            result.run_length = count;
          end
          CH_DOLLAR: begin
            cur_col_next = start_col;
            cur_row_next = row_sat;
          end
          default: begin
            cur_col_next = cur_col;
          end
        endcase
      end
    end
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode <= MODE_START;
      phase     <= HP_WIDTH;
      acc       <= '0;
      seen      <= 1'b0;
      pat_w     <= '0;
      pat_h     <= '0;
      rules     <= RULES_RESET;
      start_col <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      finished  <= 1'b0;
    end else begin
      line_mode <= line_mode_next;
      phase     <= phase_next;
      acc       <= acc_next;
      seen      <= seen_next;
      pat_w     <= pat_w_next;
      pat_h     <= pat_h_next;
      rules     <= rules_next;
      start_col <= start_col_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      finished  <= finished_next;
    end
  end

endmodule

### hw/rtl/life_rle_pattern_decoder_unit.sv
// Top level of the Life RLE pattern decoder: input register, parser core and result register.
//
//   Channel | Signals                                          | Direction
//   --------+--------------------------------------------------+----------
//   input   | in_valid, in_ready, char_byte                    | in
//   output  | out_valid, out_ready, kind, row, column,         | out
//           | run_length, used_width, used_height,             |
//           | born_count, survive_min, survive_max             |
//   config  | cfg_we, cfg_index, cfg_data                      | in
//
// One byte per cycle while no result waits. A byte is parsed once it is in the input register
// and the result register can take its result, which, if any, enters the result register at that edge.
// The parse of one byte is a single pass of add and compare logic in the core.
// Reset (rst, synchronous) empties both registers and restores the parser state.
// A waiting result holds the input register; it still takes one byte meanwhile.
module life_rle_pattern_decoder_unit
  import lrle_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            char_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [FIELD_BITS-1:0] row,
  output logic [FIELD_BITS-1:0] column,
  output logic [FIELD_BITS-1:0] run_length,
  output logic [FIELD_BITS-1:0] used_width,
  output logic [FIELD_BITS-1:0] used_height,
  output logic [RULE_BITS-1:0]  born_count,
  output logic [RULE_BITS-1:0]  survive_min,
  output logic [RULE_BITS-1:0]  survive_max,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [FIELD_BITS-1:0] cfg_data
);

  logic                  hold_valid;
  logic [7:0]            hold_byte;
  logic                  advance;
  logic [FIELD_BITS-1:0] grid_width, grid_height;
  result_t               core_result;
  result_t               out_reg;

  // The held byte moves on when the result register can take its result.
  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= char_byte;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default:         grid_width  <= grid_width;
      endcase
    end
  end

  // Parser core.
  lrle_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .char_byte  (hold_byte),
    .grid_width (grid_width),
    .grid_height(grid_height),
    .result     (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= advance && core_result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_result.valid) begin
      out_reg <= core_result;
    end
  end

  assign kind        = out_reg.kind;
  assign row         = out_reg.row;
  assign column      = out_reg.column;
  assign run_length  = out_reg.run_length;
  assign used_width  = out_reg.used_width;
  assign used_height = out_reg.used_height;
  assign born_count  = out_reg.born_count;
  assign survive_min = out_reg.survive_min;
  assign survive_max = out_reg.survive_max;

  // A held byte is never dropped while the result side is stalled.
  assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid)
    else $error("held byte lost during stall");

  // A new result only appears after the core parsed a byte.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a parsed byte");

  // Only header results carry placement and rule fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_HEADER |->
      used_width == '0 && used_height == '0 && born_count == '0 &&
      survive_min == '0 && survive_max == '0)
    else $error("placement fields set on a non-header result");

endmodule

### tb/life_rle_pattern_decoder_unit_test.sv
// Self-checking testbench for the Life RLE pattern decoder unit.
`timescale 1ns / 1ps

module life_rle_pattern_decoder_unit_test;
  import lrle_pkg::*;

  // One decoded event in the form the block reports it.
  typedef struct packed {
    result_kind_t          kind;
    logic [FIELD_BITS-1:0] row;
    logic [FIELD_BITS-1:0] column;
    logic [FIELD_BITS-1:0] run_length;
    logic [FIELD_BITS-1:0] used_width;
    logic [FIELD_BITS-1:0] used_height;
    logic [RULE_BITS-1:0]  born_count;
    logic [RULE_BITS-1:0]  survive_min;
    logic [RULE_BITS-1:0]  survive_max;
  } decode_event_t;

  // One row of the directed stimulus: a text byte and, where given, its event.
  typedef struct {
    logic [7:0]    text;
    bit            typed;
    decode_event_t outcome;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            char_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            kind;
  logic [FIELD_BITS-1:0] row;
  logic [FIELD_BITS-1:0] column;
  logic [FIELD_BITS-1:0] run_length;
  logic [FIELD_BITS-1:0] used_width;
  logic [FIELD_BITS-1:0] used_height;
  logic [RULE_BITS-1:0]  born_count;
  logic [RULE_BITS-1:0]  survive_min;
  logic [RULE_BITS-1:0]  survive_max;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [FIELD_BITS-1:0] cfg_data;

  // Events predicted but not yet seen, and the shared run controls.
  decode_event_t awaited_events[$];
  int failures = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 72;
  int pressure_asks = 0;

  // Predictor copy of the grid registers and the parser state.
  logic [15:0] grid_w;
  logic [15:0] grid_h;
  line_mode_t  line_state;
  hdr_phase_t  hdr_step;
  logic [15:0] run_count;
  bit          run_count_valid;
  logic [15:0] pat_w;
  logic [15:0] pat_h;
  logic [3:0]  born_rule;
  logic [3:0]  smin_rule;
  logic [3:0]  smax_rule;
  logic [15:0] origin_col;
  logic [15:0] cur_row;
  logic [15:0] cur_col;
  bit          pattern_done;

  logic [7:0]  text_plan[$];
  script_row_t script[$];

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  life_rle_pattern_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_byte  (char_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .row        (row),
    .column     (column),
    .run_length (run_length),
    .used_width (used_width),
    .used_height(used_height),
    .born_count (born_count),
    .survive_min(survive_min),
    .survive_max(survive_max),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Decimal accumulate, saturating at the 16-bit maximum.
  function automatic logic [15:0] dec_accum(input logic [15:0] v, input logic [7:0] c);
    int unsigned s;
    s = 32'(v) * 32'd10 + 32'(c) - 32'(CH_ZERO);
    return (s > 32'(COUNT_MAX)) ? COUNT_MAX : s[15:0];
  endfunction

  function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Rule digits are the byte minus '0', modulo 16.
  function automatic logic [3:0] rule_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return d[3:0];
  endfunction

  function automatic decode_event_t event_of(input result_kind_t k, input int unsigned r,
                                             input int unsigned col, input int unsigned len,
                                             input int unsigned uw, input int unsigned uh,
                                             input int unsigned b, input int unsigned smin,
                                             input int unsigned smax);
    decode_event_t ev;
    ev.kind        = k;
    ev.row         = 16'(r);
    ev.column      = 16'(col);
    ev.run_length  = 16'(len);
    ev.used_width  = 16'(uw);
    ev.used_height = 16'(uh);
    ev.born_count  = 4'(b);
    ev.survive_min = 4'(smin);
    ev.survive_max = 4'(smax);
    return ev;
  endfunction

  task automatic reset_decoder();
    grid_w          = GRID_RESET;
    grid_h          = GRID_RESET;
    line_state      = MODE_START;
    hdr_step        = HP_WIDTH;
    run_count       = '0;
    run_count_valid = 1'b0;
    pat_w           = '0;
    pat_h           = '0;
    born_rule       = RULES_RESET[3:0];
    smin_rule       = RULES_RESET[7:4];
    smax_rule       = RULES_RESET[11:8];
    origin_col      = '0;
    cur_row         = '0;
    cur_col         = '0;
    pattern_done    = 1'b0;
  endtask

  // One body byte: counts, tags and the end mark.
  task automatic body_byte(input logic [7:0] c, output bit emitted, output decode_event_t ev);
    logic [15:0] cnt;
    emitted = 1'b0;
    ev      = '0;
    if (pattern_done) return;
    if (c == CH_BANG) begin
      pattern_done    = 1'b1;
      run_count       = '0;
      run_count_valid = 1'b0;
      emitted         = 1'b1;
      ev = event_of(KIND_END, cur_row, cur_col, 0, 0, 0, 0, 0, 0);
    end else if (is_digit(c)) begin
      run_count       = dec_accum(run_count, c);
      run_count_valid = 1'b1;
    end else begin
      // Any other byte is a tag and consumes the count, which defaults to one.
      cnt             = run_count_valid ? run_count : 16'd1;
      run_count       = '0;
      run_count_valid = 1'b0;
      if (c == CH_LOWER_B) begin
        cur_col = sat_sum(cur_col, cnt);
      end else if (c == CH_LOWER_O) begin
        emitted = 1'b1;
        ev      = event_of(KIND_RUN, cur_row, cur_col, cnt, 0, 0, 0, 0, 0);
        cur_col = sat_sum(cur_col, cnt);
      end else if (c == CH_DOLLAR) begin
        cur_col = origin_col;
        cur_row = sat_sum(cur_row, cnt);
      end
    end
  endtask

  // Predicts the event, if any, caused by one accepted text byte.
  task automatic parse_pattern_byte(input logic [7:0] c, output bit emitted,
                                    output decode_event_t ev);
    line_mode_t  prev;
    logic [15:0] uw;
    logic [15:0] uh;
    emitted = 1'b0;
    ev      = '0;
    if (c == CH_NEWLINE) begin
      prev       = line_state;
      line_state = MODE_START;
      // A header line, complete or not, places the pattern when it ends.
      if (prev == MODE_HEADER || prev == MODE_HDR_DONE) begin
        uw              = (grid_w > pat_w) ? grid_w : pat_w;
        uh              = (grid_h > pat_h) ? grid_h : pat_h;
        origin_col      = (uw >> 1) - (pat_w >> 1);
        cur_row         = (uh - pat_h) >> 1;
        cur_col         = origin_col;
        pattern_done    = 1'b0;
        run_count       = '0;
        run_count_valid = 1'b0;
        emitted         = 1'b1;
        ev = event_of(KIND_HEADER, cur_row, origin_col, 0, uw, uh,
                      born_rule, smin_rule, smax_rule);
      end
    end else begin
      case (line_state)
        MODE_START: begin
          if (c == CH_HASH) begin
            line_state = MODE_SKIP;
          end else if (c == CH_LOWER_X) begin
            line_state = MODE_HEADER;
            hdr_step   = HP_WIDTH;
            pat_w      = '0;
            pat_h      = '0;
            born_rule  = RULES_RESET[3:0];
            smin_rule  = RULES_RESET[7:4];
            smax_rule  = RULES_RESET[11:8];
          end else begin
            line_state = MODE_BODY;
            body_byte(c, emitted, ev);
          end
        end
        MODE_HEADER: begin
          case (hdr_step)
            HP_WIDTH: begin
              if (is_digit(c)) begin
                pat_w    = dec_accum(16'd0, c);
                hdr_step = HP_WIDTH_DIGITS;
              end
            end
            HP_WIDTH_DIGITS: begin
              if (is_digit(c)) pat_w = dec_accum(pat_w, c);
              else hdr_step = HP_HEIGHT;
            end
            HP_HEIGHT: begin
              if (is_digit(c)) begin
                pat_h    = dec_accum(16'd0, c);
                hdr_step = HP_HEIGHT_DIGITS;
              end
            end
            HP_HEIGHT_DIGITS: begin
              if (is_digit(c)) pat_h = dec_accum(pat_h, c);
              else if (c == CH_UPPER_B || c == CH_LOWER_B) hdr_step = HP_BORN;
              else hdr_step = HP_RULE_LETTER;
            end
            HP_RULE_LETTER: begin
              if (c == CH_UPPER_B || c == CH_LOWER_B) hdr_step = HP_BORN;
            end
            HP_BORN: begin
              born_rule = rule_nibble(c);
              hdr_step  = HP_SURV_MIN;
            end
            HP_SURV_MIN: begin
              if (is_digit(c)) begin
                smin_rule = rule_nibble(c);
                hdr_step  = HP_SURV_MAX;
              end
            end
            default: begin
              // The byte after the survive minimum closes the header; the rest is ignored.
              smax_rule  = rule_nibble(c);
              line_state = MODE_HDR_DONE;
            end
          endcase
        end
        MODE_BODY: body_byte(c, emitted, ev);
        default: ;
      endcase
    end
  endtask

  // Offers one byte, waits for its transfer, then records what it should cause.
  task automatic send_byte(input logic [7:0] c, input bit typed, input decode_event_t given);
    bit            taken;
    bit            emitted;
    decode_event_t ev;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_byte <= c;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    parse_pattern_byte(c, emitted, ev);
    if (typed) awaited_events.push_back(given);
    else if (emitted) awaited_events.push_back(ev);
  endtask

  // Lets every predicted event arrive, then waits on for bytes still in flight.
  task automatic drain_and_rest();
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_grid(input logic [15:0] w, input logic [15:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_w = w;
    grid_h = h;
  endtask

  task automatic script_text(input string s);
    foreach (s[i]) script.push_back('{s[i], 1'b0, '0});
  endtask

  task automatic plan_text(input string s);
    foreach (s[i]) text_plan.push_back(s[i]);
  endtask

  task automatic plan_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    plan_text(s);
  endtask

  function automatic logic [7:0] any_but_newline();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == CH_NEWLINE) ? 8'h0B : c;
  endfunction

  // Pattern sizes: mostly small, some saturating, a few zero.
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 40);
    if (r < 85) return $urandom_range(41, 999);
    if (r < 95) return $urandom_range(60000, 99999);
    return 0;
  endfunction

  function automatic logic [7:0] rule_char();
    if ($urandom_range(0, 4) != 0) return 8'(CH_ZERO + $urandom_range(0, 8));
    return any_but_newline();
  endfunction

  // Header line, sometimes without rules, sometimes cut short.
  task automatic plan_header();
    int unsigned first;
    int unsigned keep;
    first = text_plan.size();
    text_plan.push_back(CH_LOWER_X);
    if ($urandom_range(0, 1)) plan_text(" = ");
    plan_number(pick_size());
    plan_text($urandom_range(0, 1) ? ", y = " : ",");
    plan_number(pick_size());
    if ($urandom_range(0, 9) != 0) begin
      plan_text(", rule = ");
      text_plan.push_back($urandom_range(0, 3) ? CH_UPPER_B : CH_LOWER_B);
      text_plan.push_back(rule_char());
      plan_text("/S");
      text_plan.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      text_plan.push_back(rule_char());
      if ($urandom_range(0, 3) == 0) plan_text(":T16,16");
    end
    if ($urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, text_plan.size() - first);
      while (text_plan.size() > first + keep) void'(text_plan.pop_back());
    end
    text_plan.push_back(CH_NEWLINE);
  endtask

  // Body tokens with random counts, split over lines, usually closed by the end mark.
  task automatic plan_body(input bit with_end);
    int unsigned r;
    repeat ($urandom_range(3, 24)) begin
      r = $urandom_range(0, 99);
      if (r < 30) plan_number($urandom_range(1, 30));
      else if (r < 35) plan_number($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1000, 200000));
      r = $urandom_range(0, 99);
      if (r < 40) text_plan.push_back(CH_LOWER_O);
      else if (r < 65) text_plan.push_back(CH_LOWER_B);
      else if (r < 85) text_plan.push_back(CH_DOLLAR);
      else text_plan.push_back(any_but_newline());
      if ($urandom_range(0, 9) == 0) text_plan.push_back(CH_NEWLINE);
    end
    if (with_end) begin
      if ($urandom_range(0, 3) == 0) plan_number($urandom_range(1, 9));
      text_plan.push_back(CH_BANG);
      if ($urandom_range(0, 2) == 0) plan_text("2o$bo");
    end
    text_plan.push_back(CH_NEWLINE);
  endtask

  // Fills the byte plan: mostly well-formed patterns, the rest noise and broken text.
  task automatic plan_phase(input int unsigned target);
    int unsigned r;
    while (text_plan.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        if (r < 20) begin
          text_plan.push_back(CH_HASH);
          repeat ($urandom_range(0, 8)) text_plan.push_back(any_but_newline());
          text_plan.push_back(CH_NEWLINE);
        end
        plan_header();
        plan_body(1'b1);
      end else if (r < 80) begin
        plan_body($urandom_range(0, 1));
      end else begin
        if (r >= 90) plan_header();
        repeat ($urandom_range(2, 12)) text_plan.push_back(8'($urandom_range(0, 255)));
        text_plan.push_back(CH_NEWLINE);
      end
    end
  endtask

  // Main stimulus: reset, directed table, then random phases at several grid sizes.
  initial begin : stimulus
    int phase;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    char_byte <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= '0;
    reset_decoder();

    // Body before any header, a comment, an empty line, a saturating header, then tags.
    script.push_back('{CH_LOWER_O, 1'b1, event_of(KIND_RUN, 0, 0, 1, 0, 0, 0, 0, 0)});
    script.push_back('{CH_BANG, 1'b1, event_of(KIND_END, 0, 1, 0, 0, 0, 0, 0, 0)});
    script_text("\n#x\n\nx99999 7B5S06");
    script.push_back('{CH_NEWLINE, 1'b1,
                       event_of(KIND_HEADER, 124, 0, 0, 65535, 256, 5, 0, 6)});
    script_text("2$3bzo!\n");

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i]) send_byte(script[i].text, script[i].typed, script[i].outcome);
    drain_and_rest();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_grid(16'd1, 16'd1);
        1: begin
          set_grid(16'hFFFF, 16'hFFFF);
          send_idle_pct = 72;
          recv_idle_pct = 37;
        end
        2: begin
          set_grid(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 64)));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        default: begin
          set_grid(16'd1, 16'hFFFF);
          pressure_asks++;
        end
      endcase
      plan_phase(180);
      foreach (text_plan[i]) send_byte(text_plan[i], 1'b0, '0);
      text_plan.delete();
      drain_and_rest();
    end

    if (failures == 0 && awaited_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: random or held-off ready, and a check of every transfer.
  initial begin : result_checker
    int            hold_left;
    int            pressure_served;
    decode_event_t want;
    hold_left       = 0;
    pressure_served = 0;
    out_ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(posedge clk);
      if (pressure_served != pressure_asks) begin
        pressure_served = pressure_asks;
        hold_left       = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(negedge clk);
      if (out_valid && out_ready) begin
        if (awaited_events.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, got kind %0d row %0d column %0d",
                   $time, kind, row, column);
        end else begin
          want = awaited_events.pop_front();
          check_field("kind", want.kind, kind);
          check_field("row", want.row, row);
          check_field("column", want.column, column);
          check_field("run_length", want.run_length, run_length);
          check_field("used_width", want.used_width, used_width);
          check_field("used_height", want.used_height, used_height);
          check_field("born_count", want.born_count, born_count);
          check_field("survive_min", want.survive_min, survive_min);
          check_field("survive_max", want.survive_max, survive_max);
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/lrle_pkg.sv
hw/rtl/lrle_core.sv
hw/rtl/life_rle_pattern_decoder_unit.sv
tb/life_rle_pattern_decoder_unit_test.sv
